FILE: rtl/mvbc_pkg.sv
// Shared types and constants of the mesh vertex boundary classifier.
package mvbc_pkg;

	localparam int VTX_W = 10;
	localparam int CNT_W = 2;
	localparam int NUM_CORNERS = 3;

	// Counts saturate here; a vertex is internal above the threshold.
	localparam logic [CNT_W-1:0] COUNT_LIMIT    = 2'd3;
	localparam logic [CNT_W-1:0] INTERNAL_ABOVE = 2'd2;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_VERTEX   = 2'd1,
		CMD_TRIANGLE = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic [VTX_W-1:0] vertex_c;
	} req_t;

	typedef struct packed {
		logic internal;
		logic about_triangle;
	} res_t;

	// Decoded request as it travels from the front to the back.
	typedef struct packed {
		cmd_t                              op;
		logic [NUM_CORNERS-1:0][VTX_W-1:0] vtx;
		logic [NUM_CORNERS-1:0]            in_range;
	} entry_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ISSUE
	} back_state_t;

endpackage

FILE: rtl/mesh_vertex_boundary_classifier.sv
// Top level of the mesh vertex boundary classifier.
// Keeps a saturating 2-bit occurrence count per vertex in a single-port-read,
// single-port-write RAM of MAX_VERTICES entries, and answers vertex and triangle
// queries (internal when a count exceeds 2). An add triangle request and a triangle
// query make one count memory access per corner; a vertex query makes one. A clear
// request waits for reads in flight, longer while a finished query result is held
// back by res_ready, then sweeps every entry of the memory to zero. After reset the
// same sweep runs first, with req_ready low. A query result passes from the read
// stage of its last corner into an output register and sits there; a two-entry
// request queue lets new requests be taken while the back end works or waits.
module mesh_vertex_boundary_classifier #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mvbc_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output mvbc_pkg::res_t res
);
	import mvbc_pkg::*;

	entry_t q_entry;
	entry_t q_head;
	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	logic   init_busy;

	// Request decode.
	mvbc_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.hold     (init_busy),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	// Decoupling queue.
	mvbc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_entry),
		.full  (q_full),
		.pop   (q_pop),
		.empty (q_empty),
		.dout  (q_head)
	);

	// Count memory and command execution.
	mvbc_back #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.init_busy(init_busy),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

FILE: rtl/mvbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read ports; a read of the address written in the same cycle returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/mvbc_queue.sv
// Two-entry queue of decoded requests between the front and the back.
module mvbc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mvbc_pkg::entry_t din,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output mvbc_pkg::entry_t dout
);
	import mvbc_pkg::*;

	localparam int DEPTH = 2;

	entry_t                       mem_q [DEPTH];
	logic [$clog2(DEPTH)-1:0]     wr_q;
	logic [$clog2(DEPTH)-1:0]     rd_q;
	logic [$clog2(DEPTH+1)-1:0]   cnt_q;

	assign full  = (cnt_q == ($clog2(DEPTH+1))'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

FILE: rtl/mvbc_front.sv
// Front end: accepts requests, checks vertex ranges and queues decoded commands.
module mvbc_front #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic             req_valid,
	output logic             req_ready,
	input  mvbc_pkg::req_t   req,
	input  logic             hold,
	input  logic             q_full,
	output logic             q_push,
	output mvbc_pkg::entry_t q_entry
);
	import mvbc_pkg::*;

	// Accept while the queue has room and the power-up clearing pass is done.
	assign req_ready = !q_full && !hold;
	assign q_push    = req_valid && req_ready;

	// Decode: gather the corners and flag indices outside the vertex store.
	always_comb begin
		q_entry.op     = req.cmd;
		q_entry.vtx[0] = req.vertex_a;
		q_entry.vtx[1] = req.vertex_b;
		q_entry.vtx[2] = req.vertex_c;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			q_entry.in_range[i] = (32'(q_entry.vtx[i]) < MAX_VERTICES);
		end
	end

endmodule

FILE: rtl/mvbc_back.sv
// Back end: runs count updates, queries and clears against the count memory.
module mvbc_back #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  mvbc_pkg::entry_t q_head,
	output logic             q_pop,
	output logic             init_busy,
	output logic             res_valid,
	input  logic             res_ready,
	output mvbc_pkg::res_t   res
);
	import mvbc_pkg::*;

	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);

	back_state_t       state_q, state_d;
	logic [1:0]        step_q, step_d;
	logic [ADDR_W-1:0] sweep_q, sweep_d;
	entry_t            cmd_q, cmd_d;
	logic              init_q, init_d;

	// Read stage: one corner in flight while its count comes back.
	logic              valid_s1;
	cmd_t              op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              in_range_s1;
	logic              first_s1;
	logic              last_s1;

	logic              issue;
	logic [ADDR_W-1:0] issue_addr;
	logic              issue_in_range;
	logic              issue_last;

	// Last write, bypassed to a read that raced it.
	logic              fwd_vld_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [CNT_W-1:0]  fwd_val_q;

	logic              acc_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CNT_W-1:0]  wdata;
	logic              re;
	logic [CNT_W-1:0]  rdata;

	logic [CNT_W-1:0]  count;
	logic              hit;
	logic              acc_next;
	logic              stall;
	logic              deliver;
	logic [VTX_W+ADDR_W-1:0] vtx_ext;

	mvbc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_VERTICES)
	) u_count_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(issue_addr),
		.rdata(rdata)
	);

	assign init_busy = init_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Count of the corner in the read stage, with the last write bypassed.
	always_comb begin
		count    = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_val_q : rdata;
		hit      = in_range_s1 && (count > INTERNAL_ABOVE);
		acc_next = (first_s1 ? 1'b0 : acc_q) | hit;
		stall    = valid_s1 && (op_s1 != CMD_ADD) && last_s1 && res_valid_q && !res_ready;
		deliver  = valid_s1 && (op_s1 != CMD_ADD) && last_s1 && !stall;
	end

	// Memory write: saturating increment for an add, zero during a sweep.
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = (count == COUNT_LIMIT) ? count : count + 1'b1;
		if (state_q == ST_SWEEP) begin
			we    = 1'b1;
			waddr = sweep_q;
			wdata = '0;
		end else if (valid_s1 && op_s1 == CMD_ADD && in_range_s1) begin
			we = 1'b1;
		end
	end

	// Sequencer: pops commands, steps through corners, sweeps on clear.
	always_comb begin
		logic start;
		logic [1:0] last_step;
		start          = 1'b0;
		last_step      = (cmd_q.op == CMD_VERTEX) ? 2'd0 : 2'd2;
		state_d        = state_q;
		step_d         = step_q;
		sweep_d        = sweep_q;
		cmd_d          = cmd_q;
		init_d         = init_q;
		q_pop          = 1'b0;
		issue          = 1'b0;
		vtx_ext        = {{ADDR_W{1'b0}}, cmd_q.vtx[step_q]};
		issue_addr     = vtx_ext[ADDR_W-1:0];
		issue_in_range = cmd_q.in_range[step_q];
		issue_last     = (step_q == last_step);
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = ST_IDLE;
					init_d  = 1'b0;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_IDLE: begin
				start = 1'b1;
			end
			ST_ISSUE: begin
				if (!stall) begin
					issue = 1'b1;
					if (issue_last) begin
						start   = 1'b1;
						state_d = ST_IDLE;
					end else begin
						step_d = step_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// A clear waits until no read is in flight, so the sweep owns the write port.
		if (start && !stall && !q_empty) begin
			if (q_head.op == CMD_CLEAR) begin
				if (state_q == ST_IDLE && !valid_s1) begin
					q_pop   = 1'b1;
					state_d = ST_SWEEP;
					sweep_d = '0;
				end
			end else begin
				q_pop   = 1'b1;
				cmd_d   = q_head;
				step_d  = '0;
				state_d = ST_ISSUE;
			end
		end
	end

	assign re = issue;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			step_q      <= '0;
			sweep_q     <= '0;
			init_q      <= 1'b1;
			valid_s1    <= 1'b0;
			fwd_vld_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sweep_q <= sweep_d;
			init_q  <= init_d;
			if (!stall) begin
				valid_s1  <= issue;
				fwd_vld_q <= we;
			end
			if (deliver) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (!stall) begin
			fwd_addr_q <= waddr;
			fwd_val_q  <= wdata;
			if (issue) begin
				op_s1       <= cmd_q.op;
				addr_s1     <= issue_addr;
				in_range_s1 <= issue_in_range;
				first_s1    <= (step_q == 2'd0);
				last_s1     <= issue_last;
			end
			if (valid_s1) begin
				acc_q <= acc_next;
			end
		end
		if (deliver) begin
			res_q.internal       <= acc_next;
			res_q.about_triangle <= (op_s1 == CMD_TRIANGLE);
		end
	end

endmodule
